@@ hw/rtl/btmx_pkg.sv @@
// btmx_pkg: shared constants for the binary trie maximum-xor block
// no dependencies; imported by the top level
package btmx_pkg;

	// default sizes, handed down as module parameters
	localparam int KEY_BITS_DEF   = 32;
	localparam int NODE_DEPTH_DEF = 131072;

	// command codes carried in the input word
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

endpackage

@@ hw/rtl/btmx_stream_if.sv @@
// btmx_in_if / btmx_out_if: valid/ready channels of the trie block
// depends on nothing; the key width is a parameter of each interface
interface btmx_in_if #(parameter int KEY_BITS = 32);
	logic                valid;
	logic                ready;
	logic                command;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink   (input valid, input command, input key, output ready);
endinterface

interface btmx_out_if #(parameter int KEY_BITS = 32);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] max_xor;
	logic                pool_full;

	modport source (output valid, output max_xor, output pool_full, input ready);
	modport sink   (input valid, input max_xor, input pool_full, output ready);
endinterface

@@ hw/rtl/btmx_node_ram.sv @@
// btmx_node_ram: node pool of child-link pairs, one write and one read port
// registered read data; the root entry reads as zero until first written
module btmx_node_ram #(
	parameter int NODE_DEPTH = 131072,
	parameter int NODE_W     = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [NODE_W-1:0]   waddr,
	input  logic [2*NODE_W-1:0] wdata,
	input  logic [NODE_W-1:0]   raddr,
	output logic [2*NODE_W-1:0] rdata
);
	logic [2*NODE_W-1:0] mem [NODE_DEPTH];
	logic [2*NODE_W-1:0] rdata_q;
	logic                rd_root_q;
	logic                root_ok_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// root guard: remembers whether the root entry has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_ok_q <= 1'b0;
			rd_root_q <= 1'b0;
		end else begin
			rd_root_q <= (raddr == '0);
			if (we && (waddr == '0)) begin
				root_ok_q <= 1'b1;
			end
		end
	end

	assign rdata = (rd_root_q && !root_ok_q) ? '0 : rdata_q;

endmodule

@@ hw/rtl/binary_trie_max_xor_top.sv @@
// binary_trie_max_xor_top: binary trie with insert and maximum-xor query
// depends on btmx_pkg, btmx_stream_if.sv and btmx_node_ram
// steps: a query walks down one node per key bit, an insert walks and then adds
//   the missing nodes, and a refused insert goes straight to the result
// throughput: one word at a time, next word taken once the result is queued
// reset: control state and node count cleared; pool memory is not swept,
//   the root reads as empty until the first insert writes it
module binary_trie_max_xor_top #(
	parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
	parameter int NODE_DEPTH = btmx_pkg::NODE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	btmx_in_if.sink      in_ch,
	btmx_out_if.source   out_ch
);
	import btmx_pkg::*;

	localparam int NODE_W = $clog2(NODE_DEPTH);
	localparam int LVL_W  = $clog2(KEY_BITS);

	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_FILL, ST_LEAF, ST_FINISH} state_t;

	state_t              state_q;
	logic                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [NODE_W-1:0]   node_q;
	logic [NODE_W-1:0]   used_q;
	logic [KEY_BITS-1:0] partner_q;
	logic [KEY_BITS-1:0] res_xor_q;
	logic                res_full_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_xor_q;
	logic                out_full_q;

	logic                ram_we;
	logic [NODE_W-1:0]   ram_waddr;
	logic [2*NODE_W-1:0] ram_wdata;
	logic [NODE_W-1:0]   ram_raddr;
	logic [2*NODE_W-1:0] ram_rdata;

	logic [NODE_W-1:0]   link0;
	logic [NODE_W-1:0]   link1;
	logic [NODE_W-1:0]   link_same;
	logic [NODE_W-1:0]   link_opp;
	logic                kbit;
	logic [NODE_W-1:0]   fresh;
	logic [NODE_W:0]     free_nodes;
	logic                pool_low;
	logic [NODE_W-1:0]   walk_next;
	logic                walk_hit;
	logic                pbit;
	logic [KEY_BITS-1:0] partner_next;
	logic                out_load;

	btmx_node_ram #(
		.NODE_DEPTH (NODE_DEPTH),
		.NODE_W     (NODE_W)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	// decode the node word read at this level
	assign link0     = ram_rdata[NODE_W-1:0];
	assign link1     = ram_rdata[2*NODE_W-1:NODE_W];
	assign kbit      = key_q[lvl_q];
	assign link_same = kbit ? link1 : link0;
	assign link_opp  = kbit ? link0 : link1;
	assign fresh     = used_q + 1'b1;

	// free node check before an insert starts
	assign free_nodes = (NODE_W+1)'(NODE_DEPTH - 1) - {1'b0, used_q};
	assign pool_low   = free_nodes < (NODE_W+1)'(KEY_BITS);

	// next node and partner bit for the walk
	always_comb begin
		walk_hit  = 1'b1;
		walk_next = node_q;
		pbit      = 1'b0;
		if (cmd_q == CMD_QUERY) begin
			if (link_opp != '0) begin
				walk_next = link_opp;
				pbit      = ~kbit;
			end else if (link_same != '0) begin
				walk_next = link_same;
				pbit      = kbit;
			end
		end else begin
			walk_hit  = (link_same != '0);
			walk_next = link_same;
		end
	end

	assign partner_next = {partner_q[KEY_BITS-2:0], pbit};

	// result word moves into the output register
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ch.ready);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = '0;
		ram_raddr = node_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
			end
			ST_WALK: begin
				ram_raddr = walk_next;
				if ((cmd_q == CMD_INSERT) && !walk_hit) begin
					ram_we    = 1'b1;
					ram_wdata = kbit ? {fresh, link0} : {link1, fresh};
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = kbit ? {fresh, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, fresh};
			end
			ST_LEAF: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cmd_q      <= in_ch.command;
						key_q      <= in_ch.key;
						lvl_q      <= LVL_W'(KEY_BITS - 1);
						node_q     <= '0;
						partner_q  <= '0;
						res_xor_q  <= '0;
						res_full_q <= (in_ch.command == CMD_INSERT) && pool_low;
						if ((in_ch.command == CMD_INSERT) && pool_low) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					partner_q <= partner_next;
					if ((cmd_q == CMD_INSERT) && !walk_hit) begin
						used_q <= fresh;
						node_q <= fresh;
						if (lvl_q == '0) begin
							state_q <= ST_LEAF;
						end else begin
							lvl_q   <= lvl_q - 1'b1;
							state_q <= ST_FILL;
						end
					end else begin
						node_q <= walk_next;
						if (lvl_q == '0) begin
							if (cmd_q == CMD_QUERY) begin
								res_xor_q <= key_q ^ partner_next;
							end
							state_q <= ST_FINISH;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end
				end
				ST_FILL: begin
					used_q <= fresh;
					node_q <= fresh;
					if (lvl_q == '0) begin
						state_q <= ST_LEAF;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				ST_LEAF: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						out_xor_q  <= res_xor_q;
						out_full_q <= res_full_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.max_xor   = out_xor_q;
	assign out_ch.pool_full = out_full_q;

endmodule

@@ hw/rtl/btmx_checker.sv @@
// btmx_checker: port-level assertions for binary_trie_max_xor_top
// depends on the top level's channel ports; attached by the bind below
module btmx_checker #(
	parameter int KEY_BITS = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [KEY_BITS-1:0] max_xor,
	input logic                pool_full
);

	// one word in flight: no second word the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// a refused insert reports zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pool_full) |-> (max_xor == '0))
		else $error("pool_full word with nonzero max_xor");

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(max_xor) && $stable(pool_full)))
		else $error("result payload changed while stalled");

endmodule

bind binary_trie_max_xor_top btmx_checker #(.KEY_BITS(KEY_BITS)) u_btmx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.max_xor   (out_ch.max_xor),
	.pool_full (out_ch.pool_full)
);
